### src/sprite_screen_projection_macros.svh
// Assertion macros used by the checker of the sprite projection block.
`ifndef SPRITE_SCREEN_PROJECTION_MACROS_SVH
`define SPRITE_SCREEN_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSP_CHECK(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSP_HOLD(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/ssp_pkg.sv
package ssp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_RES    = 4096;
  localparam int RES_W      = 13;
  localparam int HALF_W     = RES_W - 1;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = COORD_W + DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int SUM_W      = CROSS_W + 1;
  localparam int DEN_W      = CROSS_W;
  localparam int QUO_W      = 32;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int NUM_D_W    = CROSS_W + FRAC_BITS;
  localparam int NUM_C_W    = SUM_W + HALF_W;
  localparam int NUM_S_W    = CROSS_W + RES_W;
  localparam int NUM_M_W    = (NUM_C_W > NUM_S_W) ? NUM_C_W : NUM_S_W;
  localparam int NUM_W      = (NUM_D_W > NUM_M_W) ? NUM_D_W : NUM_M_W;
  localparam int SHW        = DEN_W + QUO_W;
  localparam int PRE_STAGES = 5;
  localparam int PIPE_STAGES = PRE_STAGES + DIV_STAGES + 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [RES_W-1:0] WIDTH_RESET  = RES_W'(640);
  localparam logic [RES_W-1:0] HEIGHT_RESET = RES_W'(480);

  localparam logic [31:0] DEPTH_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] DEPTH_NEG_MIN = 32'h8000_0000;
  localparam logic [23:0] CENTRE_POS_MAX = 24'h7F_FFFF;
  localparam logic [23:0] CENTRE_NEG_MIN = 24'h80_0000;
  localparam logic [15:0] SIZE_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } ssp_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sprite_x;
    logic signed [COORD_W-1:0] sprite_y;
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic signed [COORD_W-1:0] facing_x;
    logic signed [COORD_W-1:0] facing_y;
    logic signed [COORD_W-1:0] lens_x;
    logic signed [COORD_W-1:0] lens_y;
  } ssp_in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] depth;
    logic signed [23:0] centre_column;
    logic        [15:0] on_screen_size;
    logic        [12:0] top_row;
    logic        [12:0] bottom_row;
    logic        [22:0] left_column;
    logic signed [23:0] right_column;
  } ssp_out_t;

  typedef struct packed {
    logic det_zero;
    logic neg_depth;
    logic neg_centre;
  } ssp_side_t;

endpackage

### src/ssp_div_pipe.sv
module ssp_div_pipe import ssp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [NUM_W-1:0] rem  [QUO_W];
  logic [DEN_W-1:0] dsr  [QUO_W];
  logic [QUO_W-1:0] qacc [DIV_STAGES];
  logic             ovfs [DIV_STAGES];

  // Flag quotients that do not fit; the bit stages then only see num < den * 2^QUO_W.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num;
      dsr[0]  <= den;
      qacc[0] <= '0;
      ovfs[0] <= SHW'(num) >= {den, QUO_W'(0)};
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
    localparam int B = QUO_W - j;
    logic [SHW-1:0] shifted;
    logic           ge;

    assign shifted = SHW'(dsr[j-1]) << B;
    assign ge      = SHW'(rem[j-1]) >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        qacc[j] <= qacc[j-1] | (ge ? (QUO_W'(1) << B) : QUO_W'(0));
        ovfs[j] <= ovfs[j-1];
      end
    end

    if (j < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= ge ? rem[j-1] - NUM_W'(shifted) : rem[j-1];
          dsr[j] <= dsr[j-1];
        end
      end
    end
  end

  assign quo = qacc[DIV_STAGES-1];
  assign ovf = ovfs[DIV_STAGES-1];

endmodule

### src/sprite_screen_projection.sv
// Sprite screen projection for a raycasting renderer.
// Sprite channel (sprite_valid/sprite_ready/sprite): one transaction carries a
// sprite world position and the camera position, direction and plane (Q16.16).
// Result channel (result_valid/result_ready/result): one transaction per sprite,
// in order, with depth, centre column, size and clamped draw bounds.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
// writes screen_width, index 1 screen_height, values above 4096 saturate. Write
// only while no sprite is in flight.
// Throughput: one sprite per cycle while the skid register is empty. Stages in
// order: offsets, cross products, determinant and numerators, magnitudes and
// dividends; the three pipelined long dividers (range check, then one quotient
// bit per stage); saturation; then the output register.
// All stages advance together. When the receiver stalls, the output register
// holds its transaction and a skid register catches the next one; only when the
// skid register is full does the pipeline freeze and sprite_ready drop.
// Reset clears all valid bits and loads 640 x 480.
module sprite_screen_projection import ssp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sprite_valid,
  output logic                 sprite_ready,
  input  ssp_in_t              sprite,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ssp_out_t             result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RES_W-1:0]     cfg_data
);

  // ---------------- configuration ----------------
  logic [RES_W-1:0]  screen_width;
  logic [RES_W-1:0]  screen_height;
  logic [RES_W-1:0]  cfg_sat;
  logic [HALF_W-1:0] half_width;
  logic [HALF_W-1:0] half_height;

  assign cfg_ready   = 1'b1;
  assign cfg_sat     = (cfg_data > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : cfg_data;
  assign half_width  = screen_width[RES_W-1:1];
  assign half_height = screen_height[RES_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_sat;
        REG_SCREEN_HEIGHT: screen_height <= cfg_sat;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Advance the whole pipe whenever the skid register is free.
  logic                   adv;
  logic [PIPE_STAGES-1:0] v;
  logic                   out_v;
  logic                   skid_v;

  assign adv          = !skid_v;
  assign sprite_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[PIPE_STAGES-2:0], sprite_valid};
    end
  end

  // ---------------- stage 0: offsets ----------------
  logic signed [DIFF_W-1:0]  sx0, sy0;
  logic signed [COORD_W-1:0] fx0, fy0, lx0, ly0;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx0 <= DIFF_W'(sprite.sprite_x) - DIFF_W'(sprite.camera_x);
      sy0 <= DIFF_W'(sprite.sprite_y) - DIFF_W'(sprite.camera_y);
      fx0 <= sprite.facing_x;
      fy0 <= sprite.facing_y;
      lx0 <= sprite.lens_x;
      ly0 <= sprite.lens_y;
    end
  end

  // ---------------- stage 1: six products ----------------
  logic signed [PROD_W-1:0] p_lf, p_fl, p_fs, p_fsy, p_ls, p_lsx;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lf  <= PROD_W'(lx0) * PROD_W'(fy0);
      p_fl  <= PROD_W'(fx0) * PROD_W'(ly0);
      p_fs  <= PROD_W'(fy0) * PROD_W'(sx0);
      p_fsy <= PROD_W'(fx0) * PROD_W'(sy0);
      p_ls  <= PROD_W'(lx0) * PROD_W'(sy0);
      p_lsx <= PROD_W'(ly0) * PROD_W'(sx0);
    end
  end

  // ---------------- stage 2: determinant and numerators ----------------
  logic signed [CROSS_W-1:0] det2, nx2, ny2;

  always_ff @(posedge clk) begin
    if (adv) begin
      det2 <= CROSS_W'(p_lf) - CROSS_W'(p_fl);
      nx2  <= CROSS_W'(p_fs) - CROSS_W'(p_fsy);
      ny2  <= CROSS_W'(p_ls) - CROSS_W'(p_lsx);
    end
  end

  // ---------------- stage 3: magnitudes and signs ----------------
  logic signed [SUM_W-1:0] sum3;
  logic [DEN_W-1:0]        det_abs3, ny_abs3;
  ssp_side_t               side3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3             <= SUM_W'(ny2) + SUM_W'(nx2);
      det_abs3         <= det2[CROSS_W-1] ? DEN_W'(-det2) : DEN_W'(det2);
      ny_abs3          <= ny2[CROSS_W-1] ? DEN_W'(-ny2) : DEN_W'(ny2);
      side3.det_zero   <= (det2 == '0);
      side3.neg_depth  <= det2[CROSS_W-1] ^ ny2[CROSS_W-1];
      // Hold the sign of ny here; fold it with the sign of the sum next stage.
      side3.neg_centre <= ny2[CROSS_W-1];
    end
  end

  // ---------------- stage 4: dividends ----------------
  logic [SUM_W-1:0]   sum_abs;
  logic [NUM_C_W-1:0] prod_c;
  logic [NUM_S_W-1:0] prod_s;
  logic [NUM_W-1:0]   num_d4, num_c4, num_s4;
  logic [DEN_W-1:0]   den_d4, den_n4;
  ssp_side_t          side4;

  assign sum_abs = sum3[SUM_W-1] ? SUM_W'(-sum3) : SUM_W'(sum3);
  assign prod_c  = NUM_C_W'(sum_abs) * NUM_C_W'(half_width);
  assign prod_s  = NUM_S_W'(det_abs3) * NUM_S_W'(screen_height);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_d4           <= NUM_W'(ny_abs3) << FRAC_BITS;
      num_c4           <= NUM_W'(prod_c);
      num_s4           <= NUM_W'(prod_s);
      den_d4           <= det_abs3;
      den_n4           <= ny_abs3;
      side4.det_zero   <= side3.det_zero;
      side4.neg_depth  <= side3.neg_depth;
      side4.neg_centre <= side3.neg_centre ^ sum3[SUM_W-1];
    end
  end

  // ---------------- dividers ----------------
  logic [QUO_W-1:0] q_d, q_c, q_s;
  logic             ovf_d, ovf_c, ovf_s;
  ssp_side_t        side_pipe [DIV_STAGES];

  ssp_div_pipe u_div_depth (
    .clk (clk), .en (adv), .num (num_d4), .den (den_d4), .quo (q_d), .ovf (ovf_d)
  );

  ssp_div_pipe u_div_centre (
    .clk (clk), .en (adv), .num (num_c4), .den (den_n4), .quo (q_c), .ovf (ovf_c)
  );

  ssp_div_pipe u_div_size (
    .clk (clk), .en (adv), .num (num_s4), .den (den_n4), .quo (q_s), .ovf (ovf_s)
  );

  // Carry the sign and zero flags alongside the dividers.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_pipe[0] <= side4;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  // ---------------- saturation stage ----------------
  ssp_side_t          side_q;
  logic               depth_zero;
  logic               valid_c;
  logic signed [31:0] depth_c;
  logic signed [23:0] centre_c;
  logic        [15:0] size_c;

  assign side_q     = side_pipe[DIV_STAGES-1];
  assign depth_zero = !ovf_d && (q_d == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      valid_c <= !side_q.det_zero && !depth_zero;

      if (!side_q.neg_depth) begin
        depth_c <= (ovf_d || q_d[31]) ? DEPTH_POS_MAX : q_d;
      end else begin
        depth_c <= (ovf_d || (q_d[31] && (q_d[30:0] != '0))) ? DEPTH_NEG_MIN : -q_d;
      end

      if (!side_q.neg_centre) begin
        centre_c <= (ovf_c || (q_c > QUO_W'(CENTRE_POS_MAX))) ? CENTRE_POS_MAX : q_c[23:0];
      end else begin
        centre_c <= (ovf_c || (q_c > QUO_W'(CENTRE_NEG_MIN))) ? CENTRE_NEG_MIN
                                                               : -q_c[23:0];
      end

      size_c <= (ovf_s || (q_s[31:16] != '0)) ? SIZE_MAX : q_s[15:0];
    end
  end

  // ---------------- draw bounds ----------------
  logic        [14:0] hs;
  logic signed [16:0] top_raw;
  logic        [16:0] bottom_raw;
  logic signed [24:0] left_raw;
  logic signed [24:0] right_raw;
  ssp_out_t           res_new;

  assign hs         = size_c[15:1];
  assign top_raw    = 17'(half_height) - 17'(hs);
  assign bottom_raw = 17'(half_height) + 17'(hs);
  assign left_raw   = 25'(centre_c) - 25'(hs);
  assign right_raw  = 25'(centre_c) + 25'(hs);

  always_comb begin
    res_new = '0;
    if (valid_c) begin
      res_new.valid_res      = 1'b1;
      res_new.depth          = depth_c;
      res_new.centre_column  = centre_c;
      res_new.on_screen_size = size_c;
      res_new.top_row        = top_raw[16] ? 13'd0 : top_raw[12:0];
      res_new.bottom_row     = (bottom_raw >= 17'(screen_height)) ? screen_height
                                                                  : bottom_raw[12:0];
      res_new.left_column    = left_raw[24] ? 23'd0 : left_raw[22:0];
      res_new.right_column   = (right_raw >= signed'(25'(screen_width)))
                               ? 24'(screen_width) : right_raw[23:0];
    end
  end

  // ---------------- output register and skid ----------------
  ssp_out_t out_q;
  ssp_out_t skid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      // Drain the skid register into the output slot.
      if (result_ready) begin
        out_q  <= skid_q;
        skid_v <= 1'b0;
      end
    end else if (v[PIPE_STAGES-1]) begin
      if (!out_v || result_ready) begin
        out_q <= res_new;
        out_v <= 1'b1;
      end else begin
        skid_q <= res_new;
        skid_v <= 1'b1;
      end
    end else if (result_ready) begin
      out_v <= 1'b0;
    end
  end

  assign result_valid = out_v;
  assign result       = out_q;

endmodule

### src/ssp_checker.sv
`include "sprite_screen_projection_macros.svh"

module ssp_checker import ssp_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     result_valid,
  input logic     result_ready,
  input ssp_out_t result
);

  `SSP_HOLD(a_res_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `SSP_HOLD(a_res_stable, result_valid && !result_ready, $stable(result), "result changed while stalled")
  `SSP_CHECK(a_invalid_zero, result_valid && !result.valid_res, (result.depth == 0) && (result.on_screen_size == 0) && (result.centre_column == 0) && (result.right_column == 0) && (result.bottom_row == 0), "invalid result carries data")
  `SSP_CHECK(a_depth_nonzero, result_valid && result.valid_res, result.depth != 0, "valid result with zero depth")
  `SSP_CHECK(a_rows_ordered, result_valid, result.top_row <= result.bottom_row, "top row below bottom row")

endmodule

bind sprite_screen_projection ssp_checker u_ssp_checker (.*);

### test/tb_sprite_screen_projection.sv
`timescale 1ns / 1ps

module tb_sprite_screen_projection;
  import ssp_pkg::*;

  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef enum int {
    MODE_FULL,
    MODE_SEND_IDLE,
    MODE_RECV_STALL,
    MODE_BOTH
  } pace_t;

  // One directed row: the sprite transaction, and optionally a result that is
  // obvious enough to type in by hand.
  typedef struct {
    ssp_in_t  item;
    bit       typed;
    ssp_out_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 sprite_valid;
  logic                 sprite_ready;
  ssp_in_t              sprite;
  logic                 result_valid;
  logic                 result_ready;
  ssp_out_t             result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RES_W-1:0]     cfg_data;

  // Shadow copy of the resolution registers.
  logic signed [127:0] scr_w;
  logic signed [127:0] scr_h;

  ssp_out_t projection_q[$];
  pace_t    pace;
  int       fails;

  sprite_screen_projection i_dut (
    .clk          (clk),
    .rst          (rst),
    .sprite_valid (sprite_valid),
    .sprite_ready (sprite_ready),
    .sprite       (sprite),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Saturate a wide value into [lo, hi].
  function automatic logic signed [127:0] clip(logic signed [127:0] v,
                                               logic signed [127:0] lo,
                                               logic signed [127:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Project one sprite through the inverse camera matrix, exactly as the block
  // does: everything held in wide integers, all divisions truncate toward zero.
  function automatic ssp_out_t project(ssp_in_t s);
    logic signed [127:0] sx, sy, fx, fy, lx, ly;
    logic signed [127:0] det, nx, ny, dep, ctr, sz, hs, top, bot, lft, rgt;
    ssp_out_t r;
    r = '0;
    sx = 128'(s.sprite_x) - 128'(s.camera_x);
    sy = 128'(s.sprite_y) - 128'(s.camera_y);
    fx = s.facing_x;
    fy = s.facing_y;
    lx = s.lens_x;
    ly = s.lens_y;
    det = lx * fy - fx * ly;
    nx = fy * sx - fx * sy;
    ny = lx * sy - ly * sx;
    // Degenerate camera: drop the sprite.
    if (det == 0) return r;
    dep = clip((ny <<< FRAC_BITS) / det, -128'sd2147483648, 128'sd2147483647);
    // Depth that truncates to zero: drop the sprite too.
    if (dep == 0) return r;
    ctr = clip(((ny + nx) * (scr_w / 2)) / ny, -128'sd8388608, 128'sd8388607);
    sz = (det * scr_h) / ny;
    if (sz < 0) sz = -sz;
    sz = clip(sz, 0, 65535);
    hs = sz / 2;
    top = scr_h / 2 - hs;
    if (top < 0) top = 0;
    bot = scr_h / 2 + hs;
    if (bot >= scr_h) bot = scr_h;
    lft = ctr - hs;
    if (lft < 0) lft = 0;
    rgt = ctr + hs;
    if (rgt >= scr_w) rgt = scr_w;
    r.valid_res      = 1'b1;
    r.depth          = dep[31:0];
    r.centre_column  = ctr[23:0];
    r.on_screen_size = sz[15:0];
    r.top_row        = top[12:0];
    r.bottom_row     = bot[12:0];
    r.left_column    = lft[22:0];
    r.right_column   = rgt[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] span(int unsigned r);
    return $signed($urandom_range(0, 2 * r)) - $signed(r);
  endfunction

  function automatic logic [31:0] corner();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Most sprites come from a plausible scene: camera within a small map, a
  // direction and a roughly perpendicular plane, sprite near the camera.
  function automatic ssp_in_t scene();
    ssp_in_t s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      s.camera_x = span(64 * ONE);
      s.camera_y = span(64 * ONE);
      s.facing_x = span(2 * ONE);
      s.facing_y = span(2 * ONE);
      s.lens_x   = -(s.facing_y >>> 1) + span(ONE / 8);
      s.lens_y   = (s.facing_x >>> 1) + span(ONE / 8);
      s.sprite_x = s.camera_x + span($urandom_range(1, 32) * ONE);
      s.sprite_y = s.camera_y + span($urandom_range(1, 32) * ONE);
    end else if (pick < 85) begin
      s = {$urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    end else begin
      s = {corner(), corner(), corner(), corner(),
           corner(), corner(), corner(), corner()};
    end
    return s;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Receiver pacing: stall per cycle according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      case (pace)
        MODE_RECV_STALL: result_ready <= ($urandom_range(0, 99) >= 87);
        MODE_BOTH:       result_ready <= ($urandom_range(0, 99) >= 12);
        default:         result_ready <= 1'b1;
      endcase
    end
  end

  // Compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    ssp_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (projection_q.size() == 0) begin
        $error("result transaction with no sprite outstanding");
        fails++;
      end else begin
        want = projection_q.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(result.valid_res));
        check_field("depth", 32'(want.depth), 32'(result.depth));
        check_field("centre_column", 32'(want.centre_column),
                    32'(result.centre_column));
        check_field("on_screen_size", 32'(want.on_screen_size),
                    32'(result.on_screen_size));
        check_field("top_row", 32'(want.top_row), 32'(result.top_row));
        check_field("bottom_row", 32'(want.bottom_row), 32'(result.bottom_row));
        check_field("left_column", 32'(want.left_column), 32'(result.left_column));
        check_field("right_column", 32'(want.right_column),
                    32'(result.right_column));
      end
    end
  end

  // Write one resolution register and mirror it, saturating above MAX_RES.
  task automatic write_reg(ssp_reg_t idx, logic [RES_W-1:0] val);
    logic signed [127:0] sat;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sat = (val > MAX_RES) ? MAX_RES : val;
    if (idx == REG_SCREEN_WIDTH) scr_w = sat;
    else scr_h = sat;
    cfg_valid <= 1'b0;
  endtask

  // Present one sprite transaction, idling first as the phase asks, and hold it
  // until accepted. Valid is left high for the caller's next transaction.
  task automatic send(ssp_in_t s, bit typed, ssp_out_t want);
    int unsigned idle_pct;
    case (pace)
      MODE_SEND_IDLE: idle_pct = 87;
      MODE_BOTH:      idle_pct = 12;
      default:        idle_pct = 0;
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      sprite_valid <= 1'b0;
      @(posedge clk);
    end
    sprite_valid <= 1'b1;
    sprite       <= s;
    do @(posedge clk); while (!sprite_ready);
    projection_q.push_back(typed ? want : project(s));
  endtask

  task automatic drain();
    sprite_valid <= 1'b0;
    while (projection_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    ssp_out_t none;
    int widths[6];
    int heights[6];
    int unsigned n;

    widths       = '{640, 8191, 0, 1, 4097, 320};
    heights      = '{480, 4096, 0, 1, 3, 8191};
    fails        = 0;
    pace         = MODE_FULL;
    rst          = 1'b1;
    sprite_valid = 1'b0;
    sprite       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SCREEN_WIDTH;
    cfg_data     = '0;
    scr_w        = 640;
    scr_h        = 480;
    none         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows. Zero determinant and zero depth give an all-zero result.
    rw.typed = 1'b1;
    rw.want  = none;
    rw.item  = '0;
    rows.push_back(rw);
    rw.item = {8{32'h7FFF_FFFF}};
    rows.push_back(rw);
    rw.item = {8{32'h8000_0000}};
    rows.push_back(rw);
    // Sprite on top of the camera: depth is zero.
    rw.item = '{3 * ONE, 5 * ONE, 3 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    rw.typed = 1'b0;
    // Classic camera looking down -x, sprite ahead, behind, off to the side.
    rw.item = '{ONE, 5 * ONE, 6 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    rw.item = '{9 * ONE, 5 * ONE, 6 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    rw.item = '{5 * ONE, 900 * ONE, 6 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    // Very close sprite: size saturates; far sprite: size rounds to nothing.
    rw.item = '{6 * ONE - 1, 5 * ONE, 6 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    rw.item = '{-32000 * ONE, 5 * ONE, 32000 * ONE, 5 * ONE, -ONE, 0, 0, 43254};
    rows.push_back(rw);
    // Tiny camera matrix: depth saturates positive and negative.
    rw.item = '{32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 1, 0, 0, 1};
    rows.push_back(rw);
    rw.item = '{32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1, 0, 0, 1};
    rows.push_back(rw);
    rw.item = '{32'hFFFF_FFFF, 32'h1, 0, 0, ONE, ONE, -ONE, ONE};
    rows.push_back(rw);

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // Random phases, each at its own resolution, cycling through the pacing modes.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SCREEN_WIDTH, RES_W'(widths[ph]));
      write_reg(REG_SCREEN_HEIGHT, RES_W'(heights[ph]));
      pace = pace_t'(ph % 4);
      n = 0;
      repeat (225) begin
        send(scene(), 1'b0, none);
        n++;
        // Hold off mid-phase until the pipeline has emptied completely.
        if (ph == 1 && n == 100) begin
          sprite_valid <= 1'b0;
          while (projection_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
